### sv/maze_dfs_carver_top_macros.svh
// ----------------------------------------------------------------------------
// maze_dfs_carver_top_macros.svh
// Assertion helpers used by the maze carver datapath.
// ----------------------------------------------------------------------------
`ifndef MAZE_DFS_CARVER_TOP_MACROS_SVH
`define MAZE_DFS_CARVER_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define MDC_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check a condition in the cycle after a trigger, outside reset.
`define MDC_NEXT(label, clk, rst_n, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

### sv/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg
// Shared types and codes of the maze carver: payload structs, opcodes,
// directions, door bits and the controller/datapath link.
// ----------------------------------------------------------------------------
package mdc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] GRID_RESET = 5'd8;

  localparam logic [1:0] OP_RESTART = 2'd0;
  localparam logic [1:0] OP_STEP    = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [1:0] DIR_PX = 2'd0;
  localparam logic [1:0] DIR_MX = 2'd1;
  localparam logic [1:0] DIR_PY = 2'd2;
  localparam logic [1:0] DIR_MY = 2'd3;

  localparam logic [3:0] DOOR_LEFT  = 4'b0001;
  localparam logic [3:0] DOOR_RIGHT = 4'b0010;
  localparam logic [3:0] DOOR_FRONT = 4'b0100;
  localparam logic [3:0] DOOR_BACK  = 4'b1000;

  // Mark memory read address select
  localparam logic [1:0] RS_WALK = 2'd0;
  localparam logic [1:0] RS_IDX  = 2'd1;
  localparam logic [1:0] RS_SCAN = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] direction;
    logic [7:0] room_index;
  } in_item_t;

  typedef struct packed {
    logic       carved;
    logic [3:0] walker_x;
    logic [3:0] walker_y;
    logic       finished;
    logic [3:0] door_bits;
    logic [8:0] rooms_visited;
  } out_item_t;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic       restart;
    logic [1:0] rd_src;
    logic       scan;
    logic       pop;
    logic       take_doors;
    logic       wr_old;
    logic       carve;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       fin;
    logic       idx_ok;
    logic       scan_last;
    logic       can_pop;
    logic       can_carve;
    logic       clear_last;
    logic       out_free;
  } sts_t;

  // Door set on the room the walker leaves
  function automatic logic [3:0] door_own(input logic [1:0] d);
    logic [3:0] r;
    unique case (d)
      DIR_PX: r = DOOR_LEFT;
      DIR_MX: r = DOOR_RIGHT;
      DIR_PY: r = DOOR_FRONT;
      DIR_MY: r = DOOR_BACK;
    endcase
    return r;
  endfunction

  // Door set on the room the walker enters
  function automatic logic [3:0] door_other(input logic [1:0] d);
    logic [3:0] r;
    unique case (d)
      DIR_PX: r = DOOR_RIGHT;
      DIR_MX: r = DOOR_LEFT;
      DIR_PY: r = DOOR_BACK;
      DIR_MY: r = DOOR_FRONT;
    endcase
    return r;
  endfunction

endpackage

### sv/mdc_ctrl.sv
// ----------------------------------------------------------------------------
// mdc_ctrl
// Sequencer of the maze carver: clearing pass, decode, neighbour scan,
// backtrack pops, carving writes and result hand-off.
// ----------------------------------------------------------------------------
module mdc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mdc_pkg::sts_t sts,
  output mdc_pkg::cmd_t cmd
);
  import mdc_pkg::*;

  localparam logic [3:0] ST_CLEAR_RST = 4'd0;
  localparam logic [3:0] ST_CLEAR_OP  = 4'd1;
  localparam logic [3:0] ST_IDLE      = 4'd2;
  localparam logic [3:0] ST_DECODE    = 4'd3;
  localparam logic [3:0] ST_DOOR_RD   = 4'd4;
  localparam logic [3:0] ST_DOOR_LD   = 4'd5;
  localparam logic [3:0] ST_SCAN      = 4'd6;
  localparam logic [3:0] ST_EVAL      = 4'd7;
  localparam logic [3:0] ST_POP_LD    = 4'd8;
  localparam logic [3:0] ST_CARVE_OLD = 4'd9;
  localparam logic [3:0] ST_CARVE_NEW = 4'd10;
  localparam logic [3:0] ST_DONE      = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR_RST;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR_RST: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_CLEAR_OP: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = ST_DONE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts.op)
          OP_RESTART: begin
            cmd.restart = 1'b1;
            state_nxt   = ST_CLEAR_OP;
          end
          OP_STEP: begin
            state_nxt = sts.fin ? ST_DOOR_RD : ST_SCAN;
          end
          OP_READ: begin
            state_nxt = sts.idx_ok ? ST_DOOR_RD : ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_DOOR_RD: begin
        cmd.rd_src = (sts.op == OP_READ) ? RS_IDX : RS_WALK;
        state_nxt  = ST_DOOR_LD;
      end
      ST_DOOR_LD: begin
        cmd.take_doors = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.rd_src = RS_SCAN;
        if (sts.scan_last) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        // walker doors are read here for both the carve and the miss path
        cmd.rd_src = RS_WALK;
        priority if (sts.can_pop) begin
          state_nxt = ST_POP_LD;
        end else if (sts.can_carve) begin
          state_nxt = ST_CARVE_OLD;
        end else begin
          state_nxt = ST_DOOR_LD;
        end
      end
      ST_POP_LD: begin
        cmd.pop   = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_CARVE_OLD: begin
        cmd.wr_old = 1'b1;
        state_nxt  = ST_CARVE_NEW;
      end
      ST_CARVE_NEW: begin
        cmd.carve = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR_RST;
      end
    endcase
  end

endmodule

### sv/mdc_datapath.sv
// ----------------------------------------------------------------------------
// mdc_datapath
// Grid registers, walker position, room mark memory (visited and doors),
// backtrack stack memory and the output register of the maze carver.
// ----------------------------------------------------------------------------
`include "maze_dfs_carver_top_macros.svh"

module mdc_datapath #(
  parameter int MAX_WIDTH  = 16,
  parameter int MAX_HEIGHT = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mdc_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mdc_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mdc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  mdc_pkg::cmd_t                     cmd,
  output mdc_pkg::sts_t                     sts
);
  import mdc_pkg::*;

  localparam int SLOTS = MAX_WIDTH * MAX_HEIGHT;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int AW    = $clog2(SLOTS);
  localparam int DW    = $clog2(SLOTS + 1);
  localparam int CMPW  = DW + 8;
  localparam int RST_W = (MAX_WIDTH < 8) ? MAX_WIDTH : 8;
  localparam int RST_H = (MAX_HEIGHT < 8) ? MAX_HEIGHT : 8;

  typedef struct packed {
    logic [AW-1:0] room;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } stk_ent_t;

  typedef struct packed {
    logic          ok;
    logic [AW-1:0] room;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } nbr_t;

  // mark entry: bit 4 visited, bits 3:0 doors
  logic [4:0]     mark_mem [SLOTS];
  stk_ent_t       stk_mem  [SLOTS];

  logic [CFG_DATA_W-1:0] grid_w_r;
  logic [CFG_DATA_W-1:0] grid_h_r;
  logic [WW-1:0]         act_w_r;
  logic [HW-1:0]         act_h_r;
  logic [WW+HW-1:0]      prod;
  logic [DW-1:0]         total_r;

  in_item_t      in_r;
  logic [AW-1:0] room_r;
  logic [XW-1:0] x_r;
  logic [YW-1:0] y_r;
  logic [DW-1:0] depth_r;
  logic [DW-1:0] count_r;
  logic [AW-1:0] clr_cnt_r;
  logic [2:0]    scan_cnt_r;
  logic          pend_v_r;
  logic [1:0]    pend_dir_r;
  logic          pend_ok_r;
  logic [3:0]    free_r;
  logic          carved_r;
  logic [3:0]    doors_r;
  logic [4:0]    rd_data_r;
  stk_ent_t      stk_rd_r;
  logic          out_valid_r;
  out_item_t     out_r;

  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [4:0]    wr_data;
  logic [AW-1:0] stk_idx;
  logic [AW-1:0] idx_addr;
  nbr_t          scan_nb;
  nbr_t          move_nb;
  stk_ent_t      push_ent;

  function automatic int clamp_dim(input logic [CFG_DATA_W-1:0] v, input int maxv);
    int r;
    if (v == '0) r = 1;
    else if (int'(v) > maxv) r = maxv;
    else r = int'(v);
    return r;
  endfunction

  function automatic nbr_t nbr_of(input logic [1:0] d, input logic [AW-1:0] room,
                                  input logic [XW-1:0] x, input logic [YW-1:0] y,
                                  input logic [WW-1:0] aw, input logic [HW-1:0] ah);
    nbr_t nb;
    nb.ok   = 1'b0;
    nb.room = room;
    nb.x    = x;
    nb.y    = y;
    unique case (d)
      DIR_PX: begin
        nb.ok   = (int'(x) + 1) < int'(aw);
        nb.room = room + AW'(1);
        nb.x    = x + XW'(1);
      end
      DIR_MX: begin
        nb.ok   = (x != '0);
        nb.room = room - AW'(1);
        nb.x    = x - XW'(1);
      end
      DIR_PY: begin
        nb.ok   = (int'(y) + 1) < int'(ah);
        nb.room = room + AW'(aw);
        nb.y    = y + YW'(1);
      end
      DIR_MY: begin
        nb.ok   = (y != '0);
        nb.room = room - AW'(aw);
        nb.y    = y - YW'(1);
      end
    endcase
    return nb;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= GRID_RESET;
      grid_h_r <= GRID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_GRID_WIDTH)  grid_w_r <= cfg_data;
      if (cfg_index == CFG_GRID_HEIGHT) grid_h_r <= cfg_data;
    end
  end

  assign scan_nb  = nbr_of(scan_cnt_r[1:0], room_r, x_r, y_r, act_w_r, act_h_r);
  assign move_nb  = nbr_of(in_r.direction, room_r, x_r, y_r, act_w_r, act_h_r);
  assign stk_idx  = AW'(depth_r - DW'(1));
  assign idx_addr = AW'(in_r.room_index);
  assign prod     = act_w_r * act_h_r;
  assign push_ent = '{room: room_r, x: x_r, y: y_r};

  always_comb begin
    unique case (cmd.rd_src)
      RS_WALK: rd_addr = room_r;
      RS_IDX:  rd_addr = idx_addr;
      RS_SCAN: rd_addr = scan_nb.room;
      default: rd_addr = room_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = '0;
    priority if (cmd.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = (clr_cnt_r == '0) ? 5'b1_0000 : 5'b0_0000;
    end else if (cmd.wr_old) begin
      wr_en   = 1'b1;
      wr_addr = room_r;
      wr_data = {1'b1, rd_data_r[3:0] | door_own(in_r.direction)};
    end else if (cmd.carve) begin
      wr_en   = 1'b1;
      wr_addr = move_nb.room;
      wr_data = {1'b1, door_other(in_r.direction)};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mark_mem[wr_addr] <= wr_data;
    rd_data_r <= mark_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.carve) stk_mem[depth_r[AW-1:0]] <= push_ent;
    stk_rd_r <= stk_mem[stk_idx];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_w_r     <= WW'(RST_W);
      act_h_r     <= HW'(RST_H);
      total_r     <= DW'(RST_W * RST_H);
      room_r      <= '0;
      x_r         <= '0;
      y_r         <= '0;
      depth_r     <= '0;
      count_r     <= DW'(1);
      clr_cnt_r   <= '0;
      scan_cnt_r  <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      total_r <= DW'(prod);
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + AW'(1);
      scan_cnt_r <= cmd.scan ? scan_cnt_r + 3'd1 : 3'd0;
      pend_v_r   <= cmd.scan && !scan_cnt_r[2];
      if (cmd.restart) begin
        act_w_r   <= WW'(clamp_dim(grid_w_r, MAX_WIDTH));
        act_h_r   <= HW'(clamp_dim(grid_h_r, MAX_HEIGHT));
        room_r    <= '0;
        x_r       <= '0;
        y_r       <= '0;
        depth_r   <= '0;
        count_r   <= DW'(1);
        clr_cnt_r <= '0;
      end
      if (cmd.pop) begin
        room_r  <= stk_rd_r.room;
        x_r     <= stk_rd_r.x;
        y_r     <= stk_rd_r.y;
        depth_r <= depth_r - DW'(1);
      end
      if (cmd.carve) begin
        room_r  <= move_nb.room;
        x_r     <= move_nb.x;
        y_r     <= move_nb.y;
        depth_r <= depth_r + DW'(1);
        count_r <= count_r + DW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r     <= in_data;
      carved_r <= 1'b0;
      doors_r  <= '0;
    end
    if (cmd.scan && !scan_cnt_r[2]) begin
      pend_dir_r <= scan_cnt_r[1:0];
      pend_ok_r  <= scan_nb.ok;
    end
    if (pend_v_r) free_r[pend_dir_r] <= pend_ok_r && !rd_data_r[4];
    if (cmd.take_doors) doors_r <= rd_data_r[3:0];
    if (cmd.carve) begin
      carved_r <= 1'b1;
      doors_r  <= door_other(in_r.direction);
    end
    if (cmd.emit) begin
      out_r.carved        <= carved_r;
      out_r.walker_x      <= 4'(x_r);
      out_r.walker_y      <= 4'(y_r);
      out_r.finished      <= (count_r >= total_r);
      out_r.door_bits     <= doors_r;
      out_r.rooms_visited <= 9'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.op         = in_r.opcode;
  assign sts.fin        = (count_r >= total_r);
  assign sts.idx_ok     = CMPW'(in_r.room_index) < CMPW'(total_r);
  assign sts.scan_last  = scan_cnt_r[2];
  assign sts.can_pop    = (depth_r != '0) && (free_r == 4'b0000);
  assign sts.can_carve  = free_r[in_r.direction] && (int'(depth_r) < SLOTS);
  assign sts.clear_last = (clr_cnt_r == AW'(SLOTS - 1));
  assign sts.out_free   = !out_valid_r || !out_stall;

  `MDC_ALWAYS(a_depth_below_count, clk, rst_n, depth_r < count_r, "stack deeper than carved rooms")
  `MDC_ALWAYS(a_count_in_total, clk, rst_n, count_r <= total_r, "visited count above grid size")
  `MDC_ALWAYS(a_walker_in_grid, clk, rst_n, (int'(x_r) < int'(act_w_r)) && (int'(y_r) < int'(act_h_r)), "walker outside grid")
  `MDC_NEXT(a_carve_counts, clk, rst_n, cmd.carve, count_r == DW'($past(count_r) + DW'(1)), "carve did not count a room")

endmodule

### sv/maze_dfs_carver_top.sv
// ----------------------------------------------------------------------------
// maze_dfs_carver_top
// Randomized depth-first maze carver over a grid of rooms.
//
// Requests enter on in_valid/in_stall with opcode, direction and room_index;
// each request gives one result on out_valid/out_stall. Grid size is written
// on the cfg port (index 0 width, 1 height); the user must write it only while
// idle, the block itself does not enforce this. It takes effect at the next
// restart request; reset restores the 8 by 8 default. A read fetches the
// room's doors, or goes straight to its result for a room beyond the grid
// and for opcode three. A step scans the four neighbours through the single
// read port of the mark memory, then carves, wastes the draw or pops the
// backtrack stack (pop load, neighbour scan, re-evaluate); once finished it
// only reads the walker's doors. A restart runs the mark memory clearing pass.
// One request is worked on at a time; in_stall is high from accept until the
// result sits in the output register. A result held by out_stall keeps its
// payload; the next request is accepted meanwhile and its result waits until
// the output register frees. After reset a clearing pass writes every room
// of the mark memory with in_stall high; the grid comes up 8 by 8 with the
// walker in room 0.
// ----------------------------------------------------------------------------
module maze_dfs_carver_top #(
  parameter int MAX_WIDTH  = 16,
  parameter int MAX_HEIGHT = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mdc_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mdc_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mdc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mdc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mdc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### verif/maze_dfs_carver_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_dfs_carver_top_tb
// Self-checking bench for the maze carver. A predictor walks its own copy of
// the grid, marks and backtrack trail for every accepted request. A monitor
// compares each result field by field against the oldest prediction. The run
// covers directed corners, a back-pressure stretch and random walks over
// several grid sizes.
// ----------------------------------------------------------------------------
module maze_dfs_carver_top_tb;
  import mdc_pkg::*;

  localparam int MAX_W        = 16;
  localparam int MAX_H        = 16;
  localparam int ROOM_SLOTS   = MAX_W * MAX_H;
  localparam int ITEM_TARGET  = 1700;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 300;

  localparam logic [1:0] OP_NOP        = 2'd3;
  localparam logic [1:0] CFG_SPARE_LO  = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI  = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_GRID_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  maze_dfs_carver_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted maze state
  logic [4:0] grid_w_reg;
  logic [4:0] grid_h_reg;
  int         cols;
  int         rows;
  bit         visited [ROOM_SLOTS];
  logic [3:0] doors   [ROOM_SLOTS];
  int         trail   [ROOM_SLOTS];
  int         trail_depth;
  int         walker;
  int         rooms_seen;

  out_item_t  walker_reports [$];
  int         mismatch_count = 0;
  int         requests_sent  = 0;
  bit         idle_on        = 1'b1;
  bit         hold_request   = 1'b0;

  function automatic void restart_maze();
    cols = (grid_w_reg == 0) ? 1 : ((grid_w_reg > MAX_W) ? MAX_W : int'(grid_w_reg));
    rows = (grid_h_reg == 0) ? 1 : ((grid_h_reg > MAX_H) ? MAX_H : int'(grid_h_reg));
    for (int r = 0; r < ROOM_SLOTS; r++) begin
      visited[r] = 1'b0;
      doors[r]   = 4'd0;
    end
    visited[0]  = 1'b1;
    trail_depth = 0;
    walker      = 0;
    rooms_seen  = 1;
  endfunction

  // ROOM_SLOTS stands for a wall
  function automatic int next_room(input int room, input logic [1:0] d);
    int x;
    int y;
    x = room % cols;
    y = room / cols;
    case (d)
      DIR_PX:  return (x + 1 < cols) ? room + 1 : ROOM_SLOTS;
      DIR_MX:  return (x > 0) ? room - 1 : ROOM_SLOTS;
      DIR_PY:  return (y + 1 < rows) ? room + cols : ROOM_SLOTS;
      default: return (y > 0) ? room - cols : ROOM_SLOTS;
    endcase
  endfunction

  function automatic bit room_has_exit(input int room);
    int n;
    for (int d = 0; d < 4; d++) begin
      n = next_room(room, 2'(d));
      if (n < ROOM_SLOTS && !visited[n]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit maze_done();
    return rooms_seen >= cols * rows;
  endfunction

  function automatic out_item_t walk_maze(input in_item_t req);
    out_item_t  rep;
    int         total;
    int         n;
    logic [3:0] near_door;
    logic [3:0] far_door;
    rep   = '0;
    total = cols * rows;
    if (req.opcode == OP_RESTART) begin
      restart_maze();
      total = cols * rows;
    end else if (req.opcode == OP_STEP && rooms_seen < total) begin
      // back up along the trail until the walker has somewhere to go
      while (trail_depth > 0 && !room_has_exit(walker)) begin
        trail_depth--;
        walker = trail[trail_depth];
      end
      n = next_room(walker, req.direction);
      if (n < ROOM_SLOTS && !visited[n] && trail_depth < ROOM_SLOTS) begin
        case (req.direction)
          DIR_PX:  begin near_door = DOOR_LEFT;  far_door = DOOR_RIGHT; end
          DIR_MX:  begin near_door = DOOR_RIGHT; far_door = DOOR_LEFT;  end
          DIR_PY:  begin near_door = DOOR_FRONT; far_door = DOOR_BACK;  end
          default: begin near_door = DOOR_BACK;  far_door = DOOR_FRONT; end
        endcase
        doors[walker]      |= near_door;
        doors[n]           |= far_door;
        visited[n]          = 1'b1;
        trail[trail_depth]  = walker;
        trail_depth++;
        walker              = n;
        rooms_seen++;
        rep.carved          = 1'b1;
      end
    end
    if (req.opcode == OP_READ)
      rep.door_bits = (req.room_index < total) ? doors[req.room_index] : 4'd0;
    else if (req.opcode != OP_NOP)
      rep.door_bits = doors[walker];
    rep.walker_x      = 4'(walker % cols);
    rep.walker_y      = 4'(walker / cols);
    rep.finished      = (rooms_seen >= total);
    rep.rooms_visited = 9'(rooms_seen);
    return rep;
  endfunction

  function automatic in_item_t make_req(input logic [1:0] op, input logic [1:0] dir,
                                        input logic [7:0] idx);
    in_item_t req;
    req.opcode     = op;
    req.direction  = dir;
    req.room_index = idx;
    return req;
  endfunction

  // Leaves in_valid high after accept; callers that pause go through wait_idle
  task automatic send_request(input in_item_t req);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    walker_reports = {walker_reports, walk_maze(req)};
    requests_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (walker_reports.size() > 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write width and height, optionally also the unused indexes
  task automatic set_grid(input logic [4:0] w, input logic [4:0] h, input bit spare);
    int                    n;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    n = spare ? 4 : 2;
    for (int k = 0; k < n; k++) begin
      case (k)
        0:       begin idx = CFG_GRID_WIDTH;  val = w; end
        1:       begin idx = CFG_GRID_HEIGHT; val = h; end
        2:       begin idx = CFG_SPARE_LO;    val = 5'($urandom); end
        default: begin idx = CFG_SPARE_HI;    val = 5'($urandom); end
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      do @(posedge clk); while (cfg_ready !== 1'b1);
      if (idx == CFG_GRID_WIDTH) grid_w_reg = val;
      else if (idx == CFG_GRID_HEIGHT) grid_h_reg = val;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_report(input out_item_t got);
    out_item_t want;
    if (walker_reports.size() == 0) begin
      $error("result with no request pending: %h", got);
      mismatch_count++;
      return;
    end
    want = walker_reports.pop_front();
    if (got.carved !== want.carved) begin
      $error("carved: expected %0d, got %0d", want.carved, got.carved);
      mismatch_count++;
    end
    if (got.walker_x !== want.walker_x) begin
      $error("walker_x: expected %0d, got %0d", want.walker_x, got.walker_x);
      mismatch_count++;
    end
    if (got.walker_y !== want.walker_y) begin
      $error("walker_y: expected %0d, got %0d", want.walker_y, got.walker_y);
      mismatch_count++;
    end
    if (got.finished !== want.finished) begin
      $error("finished: expected %0d, got %0d", want.finished, got.finished);
      mismatch_count++;
    end
    if (got.door_bits !== want.door_bits) begin
      $error("door_bits: expected %h, got %h", want.door_bits, got.door_bits);
      mismatch_count++;
    end
    if (got.rooms_visited !== want.rooms_visited) begin
      $error("rooms_visited: expected %0d, got %0d", want.rooms_visited, got.rooms_visited);
      mismatch_count++;
    end
  endtask

  // Result side: check, then draw the stall before the next result
  initial begin : result_monitor
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        check_report(out_data);
        stall_left = idle_on ? $urandom_range(0, 10) : 0;
      end
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0) ||
          (cfg_valid === 1'b1 && cfg_ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("maze_dfs_carver_top regression: fail");
    $finish;
  end

  // Default 8 by 8 grid straight out of reset, walls at the origin
  task automatic test_power_on();
    send_request(make_req(OP_READ, DIR_PX, 8'd0));
    send_request(make_req(OP_READ, DIR_MY, 8'd63));
    send_request(make_req(OP_READ, DIR_PX, 8'd64));
    send_request(make_req(OP_READ, DIR_MY, 8'd255));
    send_request(make_req(OP_NOP, DIR_MY, 8'd255));
    send_request(make_req(OP_STEP, DIR_MX, 8'd0));
    send_request(make_req(OP_STEP, DIR_MY, 8'd170));
    send_request(make_req(OP_STEP, DIR_PX, 8'd85));
  endtask

  // Carve a 3 by 3 grid using every direction, then step once finished
  task automatic test_each_direction();
    wait_idle();
    set_grid(5'd3, 5'd3, 1'b0);
    send_request(make_req(OP_RESTART, DIR_PX, 8'd0));
    send_request(make_req(OP_STEP, DIR_PX, 8'd0));
    send_request(make_req(OP_STEP, DIR_PY, 8'd0));
    send_request(make_req(OP_STEP, DIR_MX, 8'd0));
    send_request(make_req(OP_STEP, DIR_PY, 8'd0));
    send_request(make_req(OP_STEP, DIR_PX, 8'd0));
    send_request(make_req(OP_STEP, DIR_PX, 8'd0));
    send_request(make_req(OP_STEP, DIR_MY, 8'd0));
    send_request(make_req(OP_STEP, DIR_MY, 8'd0));
    send_request(make_req(OP_STEP, DIR_MX, 8'd0));
    send_request(make_req(OP_READ, DIR_PX, 8'd4));
  endtask

  // Zero and oversize registers, then the single-room grid
  task automatic test_grid_extremes();
    wait_idle();
    set_grid(5'd0, 5'd31, 1'b1);
    send_request(make_req(OP_RESTART, DIR_MY, 8'd255));
    send_request(make_req(OP_STEP, DIR_PX, 8'd0));
    send_request(make_req(OP_STEP, DIR_PY, 8'd0));
    send_request(make_req(OP_READ, DIR_PX, 8'd15));
    send_request(make_req(OP_READ, DIR_PX, 8'd16));
    wait_idle();
    set_grid(5'd1, 5'd1, 1'b0);
    send_request(make_req(OP_RESTART, DIR_PX, 8'd0));
    send_request(make_req(OP_STEP, DIR_PY, 8'd0));
    send_request(make_req(OP_READ, DIR_PX, 8'd1));
  endtask

  // Hold the result side while requests keep coming
  task automatic test_backpressure();
    wait_idle();
    set_grid(5'd8, 5'd8, 1'b0);
    send_request(make_req(OP_RESTART, DIR_PX, 8'd0));
    idle_on      = 1'b0;
    hold_request = 1'b1;
    for (int k = 0; k < 20; k++)
      send_request(make_req(OP_STEP, 2'($urandom), 8'($urandom)));
    idle_on = 1'b1;
  endtask

  task automatic test_random_walks();
    logic [4:0] w;
    logic [4:0] h;
    logic [1:0] op;
    logic [7:0] idx;
    int         pick;
    int         cap;
    int         steps;
    int         tail;
    while (requests_sent < ITEM_TARGET) begin
      wait_idle();
      pick = $urandom_range(0, 11);
      case (pick)
        0:       begin w = 5'd16; h = 5'd16; end
        1:       begin w = 5'd31; h = 5'($urandom_range(0, 31)); end
        2:       begin w = 5'd0;  h = 5'($urandom_range(1, 8)); end
        default: begin w = 5'($urandom_range(1, 6)); h = 5'($urandom_range(1, 6)); end
      endcase
      set_grid(w, h, $urandom_range(0, 3) == 0);
      idle_on = ($urandom_range(0, 3) != 0);
      send_request(make_req(OP_RESTART, 2'($urandom), 8'($urandom)));
      cap   = (cols * rows > 64) ? 900 : 150;
      steps = 0;
      tail  = 0;
      while (steps < cap && tail < 4 && requests_sent < ITEM_TARGET) begin
        pick = $urandom_range(0, 99);
        idx  = 8'($urandom);
        if (pick < 80) begin
          op = OP_STEP;
        end else if (pick < 92) begin
          op = OP_READ;
          if (pick < 89) idx = 8'($urandom_range(0, cols * rows - 1));
        end else if (pick < 95) begin
          op = OP_NOP;
        end else if (pick < 97 && cols * rows <= 64) begin
          op = OP_RESTART;
        end else begin
          op = OP_STEP;
        end
        send_request(make_req(op, 2'($urandom), idx));
        steps++;
        if (maze_done()) tail++;
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin : main_sequence
    grid_w_reg = GRID_RESET;
    grid_h_reg = GRID_RESET;
    restart_maze();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_power_on();
    test_each_direction();
    test_grid_extremes();
    test_backpressure();
    test_random_walks();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && walker_reports.size() == 0)
      $display("maze_dfs_carver_top regression: pass");
    else
      $display("maze_dfs_carver_top regression: fail");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/mdc_pkg.sv
sv/mdc_ctrl.sv
sv/mdc_datapath.sv
sv/maze_dfs_carver_top.sv
verif/maze_dfs_carver_top_tb.sv
